// ----- hdl/oaht_pkg.sv -----
// Types, constants and a helper function shared by the hash table unit.
`timescale 1ns / 1ps

package oaht_pkg;

  // Table geometry. The home slot is the low key bits, so the size is a power of two.
  localparam int TABLE_SIZE = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 31;

  localparam logic [IDX_W-1:0] LAST_PROBE = IDX_W'(TABLE_SIZE - 1);

  // Operation code carried by an input item.
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_e;

  // Status code carried by a result item.
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // Probe sequence selected by the configuration register.
  typedef enum logic {
    MODE_LINEAR    = 1'b0,
    MODE_QUADRATIC = 1'b1
  } mode_e;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    func_e            func;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot_index;
    status_e          status;
  } out_item_t;

  // Access request to the slot store. Reads and writes never share a cycle.
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } store_req_t;

  // Slot visited by probe number probe_num starting from the home slot.
  // The sum wraps at the table size since the size is a power of two.
  function automatic logic [IDX_W-1:0] probe_slot(input logic [IDX_W-1:0] home,
                                                   input logic [IDX_W-1:0] probe_num,
                                                   input mode_e           mode);
    logic [2*IDX_W-1:0] square;
    logic [IDX_W-1:0]   offset;
    square = probe_num * probe_num;
    offset = (mode == MODE_QUADRATIC) ? square[IDX_W-1:0] : probe_num;
    return home + offset;
  endfunction

endpackage

// ----- hdl/open_address_hash_table_unit.sv -----
// Top level of the open-addressing hash table unit with its probe sequencer.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (func, key)
// out       output     out_valid_o / out_stall_i out_data_o (slot_index, status)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (probe_mode)
//
// One item is worked on at a time. An insert checks the valid flag of each
// probed slot in ST_PROBE; a search spends two states per probe, ST_PROBE
// to check the flag and issue the key memory read and ST_CMP to compare
// the registered key.
// Reset clears all valid flags at once; no clearing pass is needed.
// A result waiting on a stalled output does not block the next item's probing.

module open_address_hash_table_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  oaht_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output oaht_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);

  oaht_pkg::state_e                state_q, state_d;
  oaht_pkg::func_e                 func_q, func_d;
  logic [oaht_pkg::KEY_W-1:0]      key_q, key_d;
  logic [oaht_pkg::IDX_W-1:0]      home_q, home_d;
  logic [oaht_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [oaht_pkg::IDX_W-1:0]      cnt_q, cnt_d;
  oaht_pkg::out_item_t             res_q, res_d;
  oaht_pkg::mode_e                 mode_q;
  logic                            out_valid_q;
  oaht_pkg::out_item_t             out_data_q;

  oaht_pkg::store_req_t            store_req;
  logic [oaht_pkg::KEY_W-1:0]      rd_key;
  logic [oaht_pkg::TABLE_SIZE-1:0] slot_valid;
  logic [oaht_pkg::IDX_W-1:0]      next_idx;
  logic                            out_free;
  logic                            out_load;

  oaht_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (store_req),
    .rd_key_o (rd_key),
    .valid_o  (slot_valid)
  );

  // Configuration register, to be written only while the block is idle; the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= oaht_pkg::MODE_LINEAR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= oaht_pkg::mode_e'(cfg_data_i);
    end
  end

  // Next slot on the probe sequence and output register availability.
  assign next_idx   = oaht_pkg::probe_slot(home_q, cnt_q + 1'b1, mode_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != oaht_pkg::ST_IDLE);

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oaht_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    key_q  <= key_d;
    home_q <= home_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  // Probe sequencer: next state, store requests and result.
  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    key_d     = key_q;
    home_d    = home_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    store_req = '0;
    out_load  = 1'b0;

    unique case (state_q)
      oaht_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = in_data_i.func;
          key_d   = in_data_i.key;
          // Home slot is the key modulo the power-of-two table size.
          home_d  = in_data_i.key[oaht_pkg::IDX_W-1:0];
          idx_d   = in_data_i.key[oaht_pkg::IDX_W-1:0];
          cnt_d   = '0;
          state_d = oaht_pkg::ST_PROBE;
        end
      end

      oaht_pkg::ST_PROBE: begin
        if (func_q == oaht_pkg::FUNC_INSERT) begin
          priority if (!slot_valid[idx_q]) begin
            store_req.wr_en = 1'b1;
            store_req.idx   = idx_q;
            store_req.key   = key_q;
            res_d.slot_index = idx_q;
            res_d.status     = oaht_pkg::STATUS_OK;
            state_d          = oaht_pkg::ST_DONE;
          end else if (cnt_q == oaht_pkg::LAST_PROBE) begin
            res_d.slot_index = '0;
            res_d.status     = oaht_pkg::STATUS_FULL;
            state_d          = oaht_pkg::ST_DONE;
          end else begin
            idx_d = next_idx;
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          if (!slot_valid[idx_q]) begin
            res_d.slot_index = '0;
            res_d.status     = oaht_pkg::STATUS_MISS;
            state_d          = oaht_pkg::ST_DONE;
          end else begin
            store_req.rd_en = 1'b1;
            store_req.idx   = idx_q;
            state_d         = oaht_pkg::ST_CMP;
          end
        end
      end

      oaht_pkg::ST_CMP: begin
        // A search ends on a key match, or when it comes back home or has made every probe.
        priority if (rd_key == key_q) begin
          res_d.slot_index = idx_q;
          res_d.status     = oaht_pkg::STATUS_OK;
          state_d          = oaht_pkg::ST_DONE;
        end else if (next_idx == home_q || cnt_q == oaht_pkg::LAST_PROBE) begin
          res_d.slot_index = '0;
          res_d.status     = oaht_pkg::STATUS_MISS;
          state_d          = oaht_pkg::ST_DONE;
        end else begin
          idx_d   = next_idx;
          cnt_d   = cnt_q + 1'b1;
          state_d = oaht_pkg::ST_PROBE;
        end
      end

      oaht_pkg::ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = oaht_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = oaht_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register holds a result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hdl/oaht_store.sv -----
// Slot store: key memory with registered read and per-slot valid flags.
`timescale 1ns / 1ps

module oaht_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  oaht_pkg::store_req_t                req_i,
  output logic [oaht_pkg::KEY_W-1:0]          rd_key_o,
  output logic [oaht_pkg::TABLE_SIZE-1:0]     valid_o
);

  logic [oaht_pkg::KEY_W-1:0]      mem_q [oaht_pkg::TABLE_SIZE];
  logic [oaht_pkg::KEY_W-1:0]      rd_key_q;
  logic [oaht_pkg::TABLE_SIZE-1:0] valid_q;

  // Key memory: one write or one read per cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.idx] <= req_i.key;
    end
    if (req_i.rd_en) begin
      rd_key_q <= mem_q[req_i.idx];
    end
  end

  // Valid flags are cleared at reset and set when a slot is filled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.idx] <= 1'b1;
    end
  end

  assign rd_key_o = rd_key_q;
  assign valid_o  = valid_q;

endmodule

// ----- hdl/oaht_checker.sv -----
// Port-level checker for the hash table unit and its bind statement.
`timescale 1ns / 1ps

module oaht_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  oaht_pkg::out_item_t  out_data_o
);

  // A stalled result stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Only one item is in work: an accepted item blocks the input next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after an accepted item");

  // A failed operation reports slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != oaht_pkg::STATUS_OK
      |-> out_data_o.slot_index == '0)
    else $error("nonzero slot on a failed operation");

  // A new result only appears after an item was being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in work");

endmodule

bind open_address_hash_table_unit oaht_checker u_oaht_checker (.*);
